// ----- hdl/cps_pkg.sv -----
// Shared types, constants and field layout for the contactor precharge sequencer.
`default_nettype none
package cps_pkg;

  localparam int unsigned TICK_W     = 32;
  localparam int unsigned VOLT_W     = 16;
  localparam int unsigned CFG_W      = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned OUT_DATA_W = 8;

  localparam int unsigned VOLTAGE_BITS_DEF = 16;
  localparam int unsigned TICK_BITS_DEF    = 32;

  localparam logic [CFG_W-1:0] CONTACTOR_TIMEOUT_RST = 16'd1000;
  localparam logic [CFG_W-1:0] PRECHARGE_MIN_RST     = 16'd1000;
  localparam logic [CFG_W-1:0] PRECHARGE_TIMEOUT_RST = 16'd5000;
  localparam logic [CFG_W-1:0] POST_DELAY_RST        = 16'd500;
  localparam logic [CFG_W-1:0] BATTERY_MIN_RST       = 16'd1000;

  // Window bounds 0.905 and 1.05 as exact integer ratios 181/200 and 21/20
  localparam int unsigned LO_NUM = 181;
  localparam int unsigned LO_DEN = 200;
  localparam int unsigned HI_NUM = 21;
  localparam int unsigned HI_DEN = 20;

  typedef enum logic [2:0] {
    PH_DISABLED  = 3'd0,
    PH_NEG_CLOSE = 3'd1,
    PH_PRECHARGE = 3'd2,
    PH_POS_CLOSE = 3'd3,
    PH_DELAY     = 3'd4,
    PH_DRIVING   = 3'd5,
    PH_FAULT     = 3'd6
  } phase_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CONTACTOR_TIMEOUT = 3'd0,
    CFG_PRECHARGE_MIN     = 3'd1,
    CFG_PRECHARGE_TIMEOUT = 3'd2,
    CFG_POST_DELAY        = 3'd3,
    CFG_BATTERY_MIN       = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [VOLT_W-1:0] battery_voltage;
    logic [VOLT_W-1:0] tractive_voltage;
    logic              pos_aux_closed;
    logic              neg_aux_closed;
    logic              bms_ok;
    logic              shutdown_ok;
    logic [TICK_W-1:0] now_ms;
  } sample_t;

  typedef struct packed {
    logic [CFG_W-1:0] contactor_timeout_ms;
    logic [CFG_W-1:0] precharge_min_ms;
    logic [CFG_W-1:0] precharge_timeout_ms;
    logic [CFG_W-1:0] post_delay_ms;
    logic [CFG_W-1:0] battery_min_voltage;
  } cfg_t;

  typedef struct packed {
    phase_e next_phase;
    logic   pos_contactor_enable;
    logic   neg_contactor_enable;
    logic   precharge_enable;
  } result_t;

endpackage
`default_nettype wire

// ----- hdl/cps_step.sv -----
// Next-phase decision and enable decode for one sample.
`default_nettype none
module cps_step #(
  parameter int unsigned VOLTAGE_BITS = cps_pkg::VOLTAGE_BITS_DEF,
  parameter int unsigned TICK_BITS    = cps_pkg::TICK_BITS_DEF
) (
  input  cps_pkg::phase_e         cur_i,
  input  logic [TICK_BITS-1:0]    entry_i,
  input  cps_pkg::sample_t        smp_i,
  input  cps_pkg::cfg_t           cfg_i,
  output cps_pkg::result_t        res_o
);
  import cps_pkg::*;

  localparam int unsigned VW = (VOLTAGE_BITS < VOLT_W) ? VOLTAGE_BITS : VOLT_W;
  localparam int unsigned PW = VW + 8;

  logic [TICK_BITS-1:0] now;
  logic [VW-1:0]        ts;
  logic [VW-1:0]        bat;
  logic                 ok;
  logic                 both_aux;
  logic [CFG_W-1:0]     lim_a;
  logic [TICK_BITS-1:0] sum_a;
  logic [TICK_BITS-1:0] sum_b;
  logic                 exp_a;
  logic                 exp_b;
  logic [PW-1:0]        ts_lo;
  logic [PW-1:0]        bat_lo;
  logic [PW-1:0]        ts_hi;
  logic [PW-1:0]        bat_hi;
  logic                 in_window;
  phase_e               nxt;

  assign now      = smp_i.now_ms[TICK_BITS-1:0];
  assign ts       = smp_i.tractive_voltage[VW-1:0];
  assign bat      = smp_i.battery_voltage[VW-1:0];
  assign ok       = smp_i.shutdown_ok & smp_i.bms_ok;
  assign both_aux = smp_i.neg_aux_closed & smp_i.pos_aux_closed;

  // One shared deadline per phase, plus the precharge timeout
  always_comb begin
    case (cur_i)
      PH_PRECHARGE: lim_a = cfg_i.precharge_min_ms;
      PH_DELAY:     lim_a = cfg_i.post_delay_ms;
      default:      lim_a = cfg_i.contactor_timeout_ms;
    endcase
  end

  // deadlines wrap at the tick width
  assign sum_a = entry_i + TICK_BITS'(lim_a);
  assign sum_b = entry_i + TICK_BITS'(cfg_i.precharge_timeout_ms);
  assign exp_a = now > sum_a;
  assign exp_b = now > sum_b;

  assign ts_lo  = PW'(ts)  * PW'(LO_DEN);
  assign bat_lo = PW'(bat) * PW'(LO_NUM);
  assign ts_hi  = PW'(ts)  * PW'(HI_DEN);
  assign bat_hi = PW'(bat) * PW'(HI_NUM);
  assign in_window = (ts_lo > bat_lo) && (ts_hi < bat_hi) &&
                     (CFG_W'(bat) > cfg_i.battery_min_voltage);

  always_comb begin
    nxt = cur_i;
    case (cur_i)
      PH_DISABLED: begin
        if (ok) nxt = PH_NEG_CLOSE;
      end
      PH_NEG_CLOSE: begin
        if (!ok)                      nxt = PH_DISABLED;
        else if (smp_i.neg_aux_closed) nxt = PH_PRECHARGE;
        else if (exp_a)               nxt = PH_FAULT;
      end
      PH_PRECHARGE: begin
        if (!ok)                     nxt = PH_DISABLED;
        else if (in_window && exp_a) nxt = PH_POS_CLOSE;
        else if (exp_b)              nxt = PH_FAULT;
      end
      PH_POS_CLOSE: begin
        if (!ok)                      nxt = PH_DISABLED;
        else if (smp_i.pos_aux_closed) nxt = PH_DELAY;
        else if (exp_a)               nxt = PH_FAULT;
      end
      PH_DELAY: begin
        if (!ok)            nxt = PH_DISABLED;
        else if (exp_a)     nxt = PH_DRIVING;
        else if (!both_aux) nxt = PH_FAULT;
      end
      PH_DRIVING: begin
        if (!ok)            nxt = PH_DISABLED;
        else if (!both_aux) nxt = PH_FAULT;
      end
      default: nxt = cur_i;
    endcase
  end

  always_comb begin
    res_o.next_phase           = nxt;
    res_o.precharge_enable     = (cur_i == PH_PRECHARGE) || (cur_i == PH_POS_CLOSE);
    res_o.neg_contactor_enable = cur_i inside {[PH_NEG_CLOSE:PH_DRIVING]};
    res_o.pos_contactor_enable = cur_i inside {[PH_POS_CLOSE:PH_DRIVING]};
  end

endmodule
`default_nettype wire

// ----- hdl/contactor_precharge_sequencer.sv -----
// Contactor precharge sequencer: sample register, phase state and result register.
// An accepted item waits in the sample register; its result then moves to the result
// register that drives the output. Throughput: one item per cycle when the output is
// not stalled; the phase register closes its update loop through the step logic,
// so back-to-back samples see each update. Reset (async, active low): phase disabled,
// entry tick 0, registers at defaults, both pipeline registers empty.
`default_nettype none
module contactor_precharge_sequencer #(
  parameter int unsigned VOLTAGE_BITS = cps_pkg::VOLTAGE_BITS_DEF,
  parameter int unsigned TICK_BITS    = cps_pkg::TICK_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // now_ms[31:0], shutdown_ok[32], bms_ok[33], neg_aux_closed[34],
  // pos_aux_closed[35], tractive_voltage[51:36], battery_voltage[67:52], zero pad
  input  logic [cps_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // precharge_enable[0], neg_contactor_enable[1], pos_contactor_enable[2],
  // next_phase[5:3], zero pad
  output logic [cps_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input  logic                            cfg_we_i,
  input  logic [cps_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [cps_pkg::CFG_W-1:0]       cfg_data_i
);
  import cps_pkg::*;

  cfg_t                 cfg_q;
  sample_t              smp_q;
  logic                 smp_vld_q;
  result_t              res_d;
  result_t              res_q;
  logic                 res_vld_q;
  phase_e               phase_q;
  logic [TICK_BITS-1:0] entry_q;
  logic                 out_free;
  logic                 advance;

  assign out_free      = !res_vld_q || m_axis_tready;
  assign advance       = smp_vld_q && out_free;
  assign s_axis_tready = !smp_vld_q || out_free;

  cps_step #(
    .VOLTAGE_BITS (VOLTAGE_BITS),
    .TICK_BITS    (TICK_BITS)
  ) u_step (
    .cur_i   (phase_q),
    .entry_i (entry_q),
    .smp_i   (smp_q),
    .cfg_i   (cfg_q),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.contactor_timeout_ms <= CONTACTOR_TIMEOUT_RST;
      cfg_q.precharge_min_ms     <= PRECHARGE_MIN_RST;
      cfg_q.precharge_timeout_ms <= PRECHARGE_TIMEOUT_RST;
      cfg_q.post_delay_ms        <= POST_DELAY_RST;
      cfg_q.battery_min_voltage  <= BATTERY_MIN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CONTACTOR_TIMEOUT: cfg_q.contactor_timeout_ms <= cfg_data_i;
        CFG_PRECHARGE_MIN:     cfg_q.precharge_min_ms     <= cfg_data_i;
        CFG_PRECHARGE_TIMEOUT: cfg_q.precharge_timeout_ms <= cfg_data_i;
        CFG_POST_DELAY:        cfg_q.post_delay_ms        <= cfg_data_i;
        CFG_BATTERY_MIN:       cfg_q.battery_min_voltage  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_vld_q <= 1'b0;
      res_vld_q <= 1'b0;
      phase_q   <= PH_DISABLED;
      entry_q   <= '0;
    end else begin
      if (s_axis_tready) smp_vld_q <= s_axis_tvalid;
      if (out_free)      res_vld_q <= smp_vld_q;
      if (advance && (res_d.next_phase != phase_q)) begin
        phase_q <= res_d.next_phase;
        entry_q <= smp_q.now_ms[TICK_BITS-1:0];
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) smp_q <= sample_t'(s_axis_tdata[$bits(sample_t)-1:0]);
    if (advance)                        res_q <= res_d;
  end

  assign m_axis_tvalid = res_vld_q;
  assign m_axis_tdata  = OUT_DATA_W'(res_q);

`ifndef SYNTHESIS
  a_fault_latched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_FAULT |=> phase_q == PH_FAULT)
    else $error("fault phase left without reset");

  a_entry_on_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(entry_q) |-> !$stable(phase_q))
    else $error("entry tick moved without a phase change");

  a_ready_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input held off while output free");

  a_pos_needs_neg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res_q.pos_contactor_enable) |-> res_q.neg_contactor_enable)
    else $error("positive contactor enabled without negative");
`endif

endmodule
`default_nettype wire

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the contactor precharge sequencer stream interface.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cps_pkg::*;

  localparam int unsigned HOLD_CYCLES     = 40;
  localparam int unsigned WATCHDOG_CYCLES = 2000;
  localparam int unsigned FLOW_ITEMS      = 70;
  localparam int unsigned SETTINGS_RUN    = 6;
  // first register index past the end of the map; writes there are dropped
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd5;

  typedef enum int {GEN_FLOW, GEN_NOISE, GEN_ADVANCE, GEN_FAULT} gen_mode_e;

  class precharge_phase_model;
    cfg_t          regs;
    phase_e        phase;
    logic [31:0]   entry_ms;
    result_t       due_q[$];
    int unsigned   mismatches;
    int unsigned   samples;
    int unsigned   checked;
    int unsigned   entries[7];

    function new();
      regs = '{CONTACTOR_TIMEOUT_RST, PRECHARGE_MIN_RST, PRECHARGE_TIMEOUT_RST,
               POST_DELAY_RST, BATTERY_MIN_RST};
      phase    = PH_DISABLED;
      entry_ms = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_CONTACTOR_TIMEOUT: regs.contactor_timeout_ms = val;
        CFG_PRECHARGE_MIN:     regs.precharge_min_ms     = val;
        CFG_PRECHARGE_TIMEOUT: regs.precharge_timeout_ms = val;
        CFG_POST_DELAY:        regs.post_delay_ms        = val;
        CFG_BATTERY_MIN:       regs.battery_min_voltage  = val;
        default: ;
      endcase
    endfunction

    // deadline wraps mod 2^32, compare stays plain unsigned
    function bit deadline_passed(logic [31:0] now, logic [CFG_W-1:0] lim);
      logic [31:0] deadline;
      deadline = entry_ms + 32'(lim);
      return now > deadline;
    endfunction

    function result_t evaluate(sample_t s);
      result_t         r;
      phase_e          nxt;
      bit              ok;
      bit              both_aux;
      bit              charged;
      longint unsigned tsv;
      longint unsigned batv;
      ok       = s.shutdown_ok && s.bms_ok;
      both_aux = s.neg_aux_closed && s.pos_aux_closed;
      tsv      = 64'(s.tractive_voltage);
      batv     = 64'(s.battery_voltage);
      charged  = (tsv * 200 > batv * 181) && (tsv * 20 < batv * 21) &&
                 (batv > 64'(regs.battery_min_voltage));
      nxt = phase;
      r.precharge_enable     = (phase == PH_PRECHARGE) || (phase == PH_POS_CLOSE);
      r.neg_contactor_enable = (phase >= PH_NEG_CLOSE) && (phase <= PH_DRIVING);
      r.pos_contactor_enable = (phase >= PH_POS_CLOSE) && (phase <= PH_DRIVING);
      case (phase)
        PH_DISABLED: if (ok) nxt = PH_NEG_CLOSE;
        PH_NEG_CLOSE: begin
          if (!ok) nxt = PH_DISABLED;
          else if (s.neg_aux_closed) nxt = PH_PRECHARGE;
          else if (deadline_passed(s.now_ms, regs.contactor_timeout_ms)) nxt = PH_FAULT;
        end
        PH_PRECHARGE: begin
          if (!ok) nxt = PH_DISABLED;
          else if (charged && deadline_passed(s.now_ms, regs.precharge_min_ms))
            nxt = PH_POS_CLOSE;
          else if (deadline_passed(s.now_ms, regs.precharge_timeout_ms)) nxt = PH_FAULT;
        end
        PH_POS_CLOSE: begin
          if (!ok) nxt = PH_DISABLED;
          else if (s.pos_aux_closed) nxt = PH_DELAY;
          else if (deadline_passed(s.now_ms, regs.contactor_timeout_ms)) nxt = PH_FAULT;
        end
        PH_DELAY: begin
          // delay expiry wins over an open aux contact
          if (!ok) nxt = PH_DISABLED;
          else if (deadline_passed(s.now_ms, regs.post_delay_ms)) nxt = PH_DRIVING;
          else if (!both_aux) nxt = PH_FAULT;
        end
        PH_DRIVING: begin
          if (!ok) nxt = PH_DISABLED;
          else if (!both_aux) nxt = PH_FAULT;
        end
        default: ;
      endcase
      r.next_phase = nxt;
      return r;
    endfunction

    function void note_sample(sample_t s);
      result_t r;
      r = evaluate(s);
      due_q.push_back(r);
      samples++;
      if (r.next_phase != phase) begin
        phase    = r.next_phase;
        entry_ms = s.now_ms;
        entries[r.next_phase]++;
      end
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] data);
      result_t got;
      result_t want;
      got = result_t'(data[$bits(result_t)-1:0]);
      checked++;
      if (due_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: unexpected item, tdata=0x%02h", checked, data);
        return;
      end
      want = due_q.pop_front();
      if (got.precharge_enable !== want.precharge_enable ||
          got.neg_contactor_enable !== want.neg_contactor_enable ||
          got.pos_contactor_enable !== want.pos_contactor_enable ||
          got.next_phase !== want.next_phase) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: exp pc/neg/pos=%0b%0b%0b ph=%0d, got %0b%0b%0b ph=%0d",
                   checked, want.precharge_enable, want.neg_contactor_enable,
                   want.pos_contactor_enable, want.next_phase, got.precharge_enable,
                   got.neg_contactor_enable, got.pos_contactor_enable, got.next_phase);
      end
    endfunction

    function int pending();
      return due_q.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_W-1:0]      cfg_data_i;

  precharge_phase_model mdl = new();
  logic [31:0] tick;
  bit          tx_no_idle;
  bit          rx_no_idle;
  bit          hold_rq;
  int unsigned idle_cycles;
  int unsigned settings_done;

  contactor_precharge_sequencer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) mdl.check_result(m_axis_tdata);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_CYCLES) begin
        $display("no item moved for %0d cycles, %0d results still due",
                 idle_cycles, mdl.pending());
        $display("[contactor_precharge_sequencer] ERROR");
        $finish;
      end
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int unsigned gap;
    bit          got;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_rq) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_rq = 1'b0;
      end else begin
        gap = rx_no_idle ? 0 : $urandom_range(0, 9);
        if (gap != 0) begin
          m_axis_tready <= 1'b0;
          repeat (gap) @(negedge clk_i);
        end
      end
      m_axis_tready <= 1'b1;
      got = 1'b0;
      while (!got) begin
        @(posedge clk_i);
        got = m_axis_tvalid;
      end
    end
  end

  function automatic sample_t pack_sample(logic [31:0] now, bit sd, bit bms, bit naux,
                                          bit paux, logic [15:0] ts, logic [15:0] bat);
    sample_t s;
    s.now_ms           = now;
    s.shutdown_ok      = sd;
    s.bms_ok           = bms;
    s.neg_aux_closed   = naux;
    s.pos_aux_closed   = paux;
    s.tractive_voltage = ts;
    s.battery_voltage  = bat;
    return s;
  endfunction

  // builds the next sample from the predicted phase so sequences get deep
  function automatic sample_t make_sample(gen_mode_e mode);
    sample_t     s;
    phase_e      ph;
    int unsigned lim;
    int unsigned bmin;
    int unsigned lo;
    int unsigned hi;
    ph   = mdl.phase;
    bmin = 32'(mdl.regs.battery_min_voltage);
    case (ph)
      PH_NEG_CLOSE, PH_POS_CLOSE: lim = 32'(mdl.regs.contactor_timeout_ms);
      PH_PRECHARGE:               lim = 32'(mdl.regs.precharge_min_ms);
      PH_DELAY:                   lim = 32'(mdl.regs.post_delay_ms);
      default:                    lim = 50;
    endcase
    s = pack_sample(tick, 1'b1, 1'b1, 1'b1, 1'b1, 16'd0, 16'($urandom));
    if (bmin < 65535) s.battery_voltage = 16'($urandom_range(bmin + 1, 65535));
    // tractive voltage strictly inside the 0.905..1.05 window
    if (s.battery_voltage != 0) begin
      lo = s.battery_voltage * 181 / 200 + 1;
      hi = (s.battery_voltage * 21 - 1) / 20;
      if (hi > 65535) hi = 65535;
      s.tractive_voltage = 16'($urandom_range(lo, hi));
    end
    case (mode)
      GEN_NOISE: begin
        s = pack_sample($urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                        16'($urandom), 16'($urandom));
        if ($urandom_range(0, 1) != 0) tick = s.now_ms;
      end
      GEN_FLOW: begin
        if ($urandom_range(0, 49) == 0) tick = 32'hFFFF_FFFF - $urandom_range(0, 2 * lim + 10);
        else tick += $urandom_range(0, lim / 2 + 2);
        s.now_ms      = tick;
        s.shutdown_ok = $urandom_range(0, 99) >= 3;
        s.bms_ok      = $urandom_range(0, 99) >= 3;
        if (ph == PH_DRIVING && $urandom_range(0, 6) == 0) s.bms_ok = 1'b0;
        s.neg_aux_closed = (ph >= PH_DELAY) ? ($urandom_range(0, 99) >= 3)
                                            : 1'($urandom_range(0, 1));
        s.pos_aux_closed = (ph >= PH_DELAY) ? ($urandom_range(0, 99) >= 3) :
                           (ph == PH_POS_CLOSE) ? 1'($urandom_range(0, 1))
                                                : ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 4) == 0) s.battery_voltage = 16'($urandom);
        if (ph != PH_PRECHARGE || $urandom_range(0, 9) < 4)
          s.tractive_voltage = 16'($urandom_range(0, s.battery_voltage));
      end
      GEN_ADVANCE: begin
        tick += lim + 1 + $urandom_range(0, 20);
        s.now_ms = tick;
      end
      default: begin
        s.tractive_voltage = 16'd0;
        if (ph == PH_NEG_CLOSE) s.neg_aux_closed = 1'b0;
        if (ph == PH_POS_CLOSE) s.pos_aux_closed = 1'b0;
        if (ph >= PH_DELAY) begin
          if ($urandom_range(0, 1) != 0) s.neg_aux_closed = 1'b0;
          else s.pos_aux_closed = 1'b0;
        end
        if (ph == PH_PRECHARGE) lim = 32'(mdl.regs.precharge_timeout_ms);
        // in delay the tick stays put so the open contact trips before expiry
        if (ph != PH_DELAY) tick += lim + 1 + $urandom_range(0, 20);
        s.now_ms = tick;
      end
    endcase
    return s;
  endfunction

  // fault latches until reset, so it is steered away from until the last stage
  task automatic drive_sample(sample_t smp, bit allow_fault);
    int unsigned gap;
    result_t     peek;
    peek = mdl.evaluate(smp);
    if (!allow_fault && peek.next_phase == PH_FAULT) begin
      if ($urandom_range(0, 1) != 0) smp.shutdown_ok = 1'b0;
      else smp.bms_ok = 1'b0;
    end
    gap = tx_no_idle ? 0 : $urandom_range(0, 9);
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_DATA_W'(smp);
    do @(posedge clk_i); while (!s_axis_tready);
    mdl.note_sample(smp);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    mdl.write_reg(idx, val);
  endtask

  task automatic program_regs(cfg_t c);
    write_reg(CFG_CONTACTOR_TIMEOUT, c.contactor_timeout_ms);
    write_reg(CFG_PRECHARGE_MIN, c.precharge_min_ms);
    write_reg(CFG_IDX_SPARE + CFG_IDX_W'($urandom_range(0, 2)), 16'($urandom));
    write_reg(CFG_PRECHARGE_TIMEOUT, c.precharge_timeout_ms);
    write_reg(CFG_POST_DELAY, c.post_delay_ms);
    write_reg(CFG_BATTERY_MIN, c.battery_min_voltage);
    settings_done++;
  endtask

  // stop offering, let every due result come out, then wait with the input idle
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (mdl.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    cfg_t        c;
    phase_e      fault_target;
    int unsigned n;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_CONTACTOR_TIMEOUT;
    cfg_data_i    = '0;
    tx_no_idle    = 1'b0;
    rx_no_idle    = 1'b0;
    hold_rq       = 1'b0;
    tick          = $urandom;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    program_regs('{CONTACTOR_TIMEOUT_RST, PRECHARGE_MIN_RST, PRECHARGE_TIMEOUT_RST,
                   POST_DELAY_RST, BATTERY_MIN_RST});

    // walk the whole sequence at reset settings, probing each boundary
    drive_sample(pack_sample(32'd0, 0, 1, 0, 0, 16'd0, 16'd0), 0);
    drive_sample(pack_sample(32'd50, 1, 0, 1, 1, 16'hFFFF, 16'hFFFF), 0);
    drive_sample(pack_sample(32'd100, 1, 1, 0, 0, 16'd0, 16'd0), 0);
    drive_sample(pack_sample(32'd1100, 1, 1, 0, 0, 16'd0, 16'd0), 0);
    drive_sample(pack_sample(32'd1101, 1, 1, 1, 0, 16'd0, 16'd0), 0);
    drive_sample(pack_sample(32'd5000, 1, 1, 1, 0, 16'd1810, 16'd2000), 0);
    drive_sample(pack_sample(32'd5001, 1, 1, 1, 0, 16'd2100, 16'd2000), 0);
    drive_sample(pack_sample(32'd5002, 1, 1, 1, 0, 16'd950, 16'd1000), 0);
    drive_sample(pack_sample(32'd2101, 1, 1, 1, 0, 16'd1811, 16'd2000), 0);
    drive_sample(pack_sample(32'd2102, 1, 1, 1, 0, 16'd2099, 16'd2000), 0);
    drive_sample(pack_sample(32'd3102, 1, 1, 1, 0, 16'd2000, 16'd2000), 0);
    drive_sample(pack_sample(32'd3000, 1, 1, 1, 1, 16'd2000, 16'd2000), 0);
    drive_sample(pack_sample(32'd3500, 1, 1, 1, 1, 16'd2000, 16'd2000), 0);
    drive_sample(pack_sample(32'd3501, 1, 1, 0, 1, 16'd2000, 16'd2000), 0);
    drive_sample(pack_sample(32'hFFFF_FFFF, 1, 1, 1, 1, 16'hFFFF, 16'hFFFF), 0);
    drive_sample(pack_sample(32'd7, 1, 0, 1, 1, 16'd0, 16'd0), 0);
    drive_sample(pack_sample(32'd8, 1, 1, 0, 0, 16'd0, 16'd0), 0);
    drive_sample(pack_sample(32'd9, 0, 1, 0, 0, 16'd0, 16'd0), 0);
    drive_sample(pack_sample(32'd10, 1, 1, 0, 0, 16'd0, 16'd0), 0);
    drive_sample(pack_sample(32'd11, 1, 1, 1, 0, 16'd0, 16'd0), 0);
    drive_sample(pack_sample(32'd12, 0, 0, 1, 1, 16'd0, 16'd0), 0);

    for (int p = 0; p < SETTINGS_RUN; p++) begin
      case (p)
        0: c = '0;
        1: c = '1;
        3: c = '{CONTACTOR_TIMEOUT_RST, PRECHARGE_MIN_RST, PRECHARGE_TIMEOUT_RST,
                 POST_DELAY_RST, BATTERY_MIN_RST};
        4: c = '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
        default: c = '{16'($urandom_range(0, 3000)), 16'($urandom_range(0, 3000)),
                       16'($urandom_range(0, 6000)), 16'($urandom_range(0, 2000)),
                       16'($urandom_range(0, 40000))};
      endcase
      settle();
      program_regs(c);
      tx_no_idle = (p == 2) || (p == 5);
      rx_no_idle = (p == 5);
      if (p == 2) hold_rq = 1'b1;
      repeat (FLOW_ITEMS)
        drive_sample(make_sample(($urandom_range(0, 4) == 0) ? GEN_NOISE : GEN_FLOW), 0);
    end

    // last stage: steer into one fault path, then confirm the latch holds
    settle();
    c = '{16'($urandom_range(1, 3000)), 16'($urandom_range(0, 3000)),
          16'($urandom_range(0, 6000)), 16'($urandom_range(0, 2000)),
          16'($urandom_range(0, 20000))};
    program_regs(c);
    tx_no_idle   = 1'b0;
    rx_no_idle   = 1'b0;
    fault_target = phase_e'($urandom_range(PH_NEG_CLOSE, PH_DRIVING));
    n = 0;
    while (mdl.phase != PH_FAULT && n < 60) begin
      drive_sample(make_sample((mdl.phase == fault_target) ? GEN_FAULT : GEN_ADVANCE), 1);
      n++;
    end
    repeat (12) drive_sample(make_sample(GEN_NOISE), 1);
    settle();

    $display("ran %0d items, %0d results, %0d register sets, one %0d-cycle output hold",
             mdl.samples, mdl.checked, settings_done, HOLD_CYCLES);
    $display("entered neg/pc/pos/dly/drv/off/flt %0d/%0d/%0d/%0d/%0d/%0d/%0d, %0d mismatches",
             mdl.entries[PH_NEG_CLOSE], mdl.entries[PH_PRECHARGE], mdl.entries[PH_POS_CLOSE],
             mdl.entries[PH_DELAY], mdl.entries[PH_DRIVING], mdl.entries[PH_DISABLED],
             mdl.entries[PH_FAULT], mdl.mismatches);
    $display("fault path aimed at phase %0d", fault_target);
    if (mdl.mismatches == 0 && mdl.pending() == 0) begin
      $display("[contactor_precharge_sequencer] OK");
    end else begin
      $display("[contactor_precharge_sequencer] ERROR");
    end
    $finish;
  end

endmodule

// ----- contactor_precharge_sequencer.f -----
hdl/cps_pkg.sv
hdl/cps_step.sv
hdl/contactor_precharge_sequencer.sv
tb/sv/tb.sv
